/* hdl/direct_dft_spectrum_assert.svh */
// ----------------------------------------------------------------------------
// direct_dft_spectrum assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef DIRECT_DFT_SPECTRUM_ASSERT_SVH
`define DIRECT_DFT_SPECTRUM_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define DDS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dds_pkg.sv */
// ----------------------------------------------------------------------------
// dds_pkg
// shared widths, codes, result type and twiddle/arctangent tables
// ----------------------------------------------------------------------------
package dds_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int LG_MAX       = ADDR_W;
    localparam int SAMPLE_WIDTH = 16;
    localparam int LG_W         = 3;
    localparam int RATE_W       = 27;
    localparam int BIN_W        = 6;
    localparam int PART_W       = 23;
    localparam int MAG_W        = 22;
    localparam int PHASE_W      = 16;
    localparam int TW_W         = 17;
    localparam int PROD_W       = SAMPLE_WIDTH + TW_W;
    localparam int ACC_W        = 38;
    localparam int SQ_W         = 44;
    localparam int COR_W        = 26;
    localparam int ANG_W        = 18;
    localparam int FREQ_PROD_W  = BIN_W + RATE_W;
    localparam int CFG_IDX_W    = 2;
    localparam int OUT_TDATA_W  = 120;

    localparam logic [LG_W-1:0]   LG_RESET   = 3'd6;
    localparam logic [RATE_W-1:0] RATE_RESET = 27'd1000000;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LOG2 = 2'd0;
    localparam t_cfg_idx CFG_RATE = 2'd1;

    // output tdata field positions
    localparam int BIN_LO   = 0;
    localparam int REAL_LO  = BIN_LO + BIN_W;
    localparam int IMAG_LO  = REAL_LO + PART_W;
    localparam int MAG_LO   = IMAG_LO + PART_W;
    localparam int PHASE_LO = MAG_LO + MAG_W;
    localparam int FREQ_LO  = PHASE_LO + PHASE_W;
    localparam int FREQ_HI  = FREQ_LO + RATE_W - 1;

    typedef struct packed {
        logic [BIN_W-1:0]          bin_index;
        logic signed [PART_W-1:0]  real_part;
        logic signed [PART_W-1:0]  imag_part;
        logic [MAG_W-1:0]          magnitude;
        logic signed [PHASE_W-1:0] phase;
        logic [RATE_W-1:0]         bin_frequency;
        logic                      last;
    } t_result;

    function automatic logic [15:0] quarter_sine(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:  v = 16'd0;
            5'd1:  v = 16'd3212;
            5'd2:  v = 16'd6393;
            5'd3:  v = 16'd9512;
            5'd4:  v = 16'd12539;
            5'd5:  v = 16'd15446;
            5'd6:  v = 16'd18204;
            5'd7:  v = 16'd20787;
            5'd8:  v = 16'd23170;
            5'd9:  v = 16'd25329;
            5'd10: v = 16'd27245;
            5'd11: v = 16'd28898;
            5'd12: v = 16'd30273;
            5'd13: v = 16'd31356;
            5'd14: v = 16'd32137;
            5'd15: v = 16'd32609;
            5'd16: v = 16'd32767;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // sine of a * 2pi/64, scaled by 32767
    function automatic logic signed [TW_W-1:0] rom_sine(input logic [ADDR_W-1:0] a);
        logic [4:0]            idx;
        logic signed [TW_W-1:0] v;
        idx = a[4] ? (5'd16 - {1'b0, a[3:0]}) : {1'b0, a[3:0]};
        v   = $signed({1'b0, quarter_sine(idx)});
        return a[5] ? -v : v;
    endfunction

    function automatic logic [13:0] atan_step(input logic [3:0] i);
        logic [13:0] v;
        case (i)
            4'd0:  v = 14'd8192;
            4'd1:  v = 14'd4836;
            4'd2:  v = 14'd2555;
            4'd3:  v = 14'd1297;
            4'd4:  v = 14'd651;
            4'd5:  v = 14'd326;
            4'd6:  v = 14'd163;
            4'd7:  v = 14'd81;
            4'd8:  v = 14'd41;
            4'd9:  v = 14'd20;
            4'd10: v = 14'd10;
            4'd11: v = 14'd5;
            4'd12: v = 14'd3;
            4'd13: v = 14'd1;
            4'd14: v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/dds_post.sv */
// ----------------------------------------------------------------------------
// dds_post
// per-bin finishing unit: magnitude, cordic phase and bin frequency
// ----------------------------------------------------------------------------
module dds_post (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [dds_pkg::PART_W-1:0]     i_re,
    input  logic signed [dds_pkg::PART_W-1:0]     i_im,
    input  logic [dds_pkg::BIN_W-1:0]             i_bin,
    input  logic [dds_pkg::LG_W-1:0]              i_lg,
    input  logic [dds_pkg::RATE_W-1:0]            i_rate,
    input  logic                                  i_last,
    input  logic                                  i_take,
    output logic                                  o_valid,
    output dds_pkg::t_result                      o_res
);

    localparam logic [4:0] CNT_SQ_LOAD = 5'd1;
    localparam logic [4:0] CNT_COR_END = 5'd15;
    localparam logic [4:0] CNT_DONE    = 5'd23;

    logic                                r_busy;
    logic                                r_valid;
    logic [4:0]                          r_cnt;
    logic signed [dds_pkg::PART_W-1:0]   r_re;
    logic signed [dds_pkg::PART_W-1:0]   r_im;
    logic [dds_pkg::BIN_W-1:0]           r_bin;
    logic [dds_pkg::LG_W-1:0]            r_lg;
    logic                                r_last;
    logic [dds_pkg::FREQ_PROD_W-1:0]     r_freq;
    logic [dds_pkg::SQ_W-1:0]            r_sqr;
    logic [dds_pkg::SQ_W-1:0]            r_sqi;
    logic [dds_pkg::SQ_W-1:0]            r_v;
    logic [dds_pkg::SQ_W-1:0]            r_root;
    logic [dds_pkg::SQ_W-1:0]            r_bit;
    logic signed [dds_pkg::COR_W-1:0]    r_x;
    logic signed [dds_pkg::COR_W-1:0]    r_y;
    logic signed [dds_pkg::ANG_W-1:0]    r_z;

    logic signed [2*dds_pkg::PART_W-1:0] sq_re;
    logic signed [2*dds_pkg::PART_W-1:0] sq_im;
    logic [dds_pkg::SQ_W:0]              sq_try;
    logic [3:0]                          cor_i;
    logic signed [dds_pkg::COR_W-1:0]    xs;
    logic signed [dds_pkg::COR_W-1:0]    ys;
    logic signed [dds_pkg::ANG_W-1:0]    atan_v;
    logic signed [dds_pkg::COR_W-1:0]    re_ext;
    logic signed [dds_pkg::COR_W-1:0]    im_ext;
    logic signed [dds_pkg::PHASE_W-1:0]  phase_sat;
    logic [dds_pkg::FREQ_PROD_W-1:0]     freq_shr;

    assign sq_re  = r_re * r_re;
    assign sq_im  = r_im * r_im;
    assign sq_try = {1'b0, r_root} + {1'b0, r_bit};
    assign cor_i  = 4'(r_cnt - 5'd1);
    assign xs     = r_x >>> cor_i;
    assign ys     = r_y >>> cor_i;
    assign atan_v = $signed({4'b0, dds_pkg::atan_step(cor_i)});
    assign re_ext = dds_pkg::COR_W'(r_re);
    assign im_ext = dds_pkg::COR_W'(r_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_take) begin
                r_valid <= 1'b0;
            end
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == CNT_DONE) begin
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_re   <= i_re;
            r_im   <= i_im;
            r_bin  <= i_bin;
            r_lg   <= i_lg;
            r_last <= i_last;
            r_freq <= dds_pkg::FREQ_PROD_W'(i_bin) * dds_pkg::FREQ_PROD_W'(i_rate);
        end else if (r_busy) begin
            if (r_cnt == 5'd0) begin
                r_sqr <= dds_pkg::SQ_W'(sq_re);
                r_sqi <= dds_pkg::SQ_W'(sq_im);
                // left half plane: rotate by pi first
                if (r_re < 0) begin
                    r_x <= -re_ext;
                    r_y <= -im_ext;
                    r_z <= (r_im >= 0) ? 18'sd32768 : -18'sd32768;
                end else begin
                    r_x <= re_ext;
                    r_y <= im_ext;
                    r_z <= '0;
                end
            end else if (r_cnt <= CNT_COR_END) begin
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_v;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_v;
                end
            end
            // restoring square root, two bits of radicand per step
            if (r_cnt == CNT_SQ_LOAD) begin
                r_v    <= r_sqr + r_sqi;
                r_root <= '0;
                r_bit  <= dds_pkg::SQ_W'(1) << (dds_pkg::SQ_W - 2);
            end else if (r_cnt > CNT_SQ_LOAD) begin
                if ({1'b0, r_v} >= sq_try) begin
                    r_v    <= r_v - sq_try[dds_pkg::SQ_W-1:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
    end

    always_comb begin
        if (r_re == 0 && r_im == 0) begin
            phase_sat = '0;
        end else if (r_z > 18'sd32767) begin
            phase_sat = 16'sh7fff;
        end else if (r_z < -18'sd32768) begin
            phase_sat = -16'sh8000;
        end else begin
            phase_sat = r_z[dds_pkg::PHASE_W-1:0];
        end
    end

    assign freq_shr = r_freq >> r_lg;

    assign o_valid             = r_valid;
    assign o_res.bin_index     = r_bin;
    assign o_res.real_part     = r_re;
    assign o_res.imag_part     = r_im;
    assign o_res.magnitude     = r_root[dds_pkg::MAG_W-1:0];
    assign o_res.phase         = phase_sat;
    assign o_res.bin_frequency = freq_shr[dds_pkg::RATE_W-1:0];
    assign o_res.last          = r_last;

endmodule

/* hdl/direct_dft_spectrum.sv */
// ----------------------------------------------------------------------------
// direct_dft_spectrum
// direct dft over 2..64 loaded samples, one result item per bin
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[15:0] sample
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata bin..freq, tlast
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  loading takes one cycle per sample item; input is held off while bins run
//  each bin runs n samples through the mac, one sample memory read per cycle,
//  then the magnitude/phase unit; one bin is in work at a time
//  a stalled output holds one finished bin; the next bin waits behind it
//  synchronous active-low reset clears control state; no clearing pass
module direct_dft_spectrum (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [dds_pkg::SAMPLE_WIDTH-1:0]       s_axis_tdata,  // [15:0] sample
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [5:0] bin_index, [28:6] real_part, [51:29] imag_part, [73:52] magnitude,
    // [89:74] phase, [116:90] bin_frequency, [119:117] zero
    output logic [dds_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tlast,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [dds_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [dds_pkg::RATE_W-1:0]             i_cfg_data
);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_POST  = 4'b1000
    } t_state;

    localparam int A = dds_pkg::ADDR_W;
    localparam int C = dds_pkg::CNT_W;

    t_state                                  r_state;
    logic [dds_pkg::LG_W-1:0]                r_lg_cfg;
    logic [dds_pkg::RATE_W-1:0]              r_rate;
    logic [C-1:0]                            r_cnt;
    logic signed [dds_pkg::SAMPLE_WIDTH-1:0] r_mem [dds_pkg::MAX_POINTS];
    logic signed [dds_pkg::SAMPLE_WIDTH-1:0] r_rd;
    logic [A-1:0]                            r_k;
    logic [C-1:0]                            r_j;
    logic [A-1:0]                            r_ang;
    logic [A-1:0]                            r_step;
    logic [A-1:0]                            r_ang_d;
    logic                                    r_v1;
    logic                                    r_v2;
    logic signed [dds_pkg::PROD_W-1:0]       r_pre;
    logic signed [dds_pkg::PROD_W-1:0]       r_pim;
    logic signed [dds_pkg::ACC_W-1:0]        r_acc_re;
    logic signed [dds_pkg::ACC_W-1:0]        r_acc_im;
    logic                                    r_out_valid;
    dds_pkg::t_result                        r_out;

    logic [dds_pkg::LG_W-1:0]                lg;
    logic [C-1:0]                            npts;
    logic [C-1:0]                            stride;
    logic [C-1:0]                            n_cnt;
    logic                                    in_acc;
    logic                                    issue;
    logic                                    post_start;
    logic                                    post_valid;
    logic                                    post_take;
    logic                                    k_last;
    logic signed [dds_pkg::ACC_W-1:0]        re_shr;
    logic signed [dds_pkg::ACC_W-1:0]        im_shr;
    dds_pkg::t_result                        post_res;

    always_comb begin
        if (r_lg_cfg == '0) begin
            lg = dds_pkg::LG_W'(1);
        end else if (r_lg_cfg > dds_pkg::LG_W'(dds_pkg::LG_MAX)) begin
            lg = dds_pkg::LG_W'(dds_pkg::LG_MAX);
        end else begin
            lg = r_lg_cfg;
        end
    end

    assign npts       = C'(1) << lg;
    assign stride     = C'(dds_pkg::MAX_POINTS) >> lg;
    assign n_cnt      = r_cnt + C'(1);
    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign issue      = (r_state == S_MAC) && (r_j < npts);
    assign post_start = (r_state == S_DRAIN) && !r_v1 && !r_v2;
    assign post_take  = (r_state == S_POST) && post_valid &&
                        (!r_out_valid || m_axis_tready);
    assign k_last     = ({1'b0, r_k} == npts - C'(1));
    assign re_shr     = r_acc_re >>> 15;
    assign im_shr     = r_acc_im >>> 15;

    assign s_axis_tready = (r_state == S_LOAD);
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_cfg <= dds_pkg::LG_RESET;
            r_rate   <= dds_pkg::RATE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dds_pkg::CFG_LOG2: r_lg_cfg <= i_cfg_data[dds_pkg::LG_W-1:0];
                dds_pkg::CFG_RATE: r_rate   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc && r_cnt < C'(dds_pkg::MAX_POINTS)) begin
            r_mem[r_cnt[A-1:0]] <= s_axis_tdata;
        end
        if (issue) begin
            r_rd <= r_mem[r_j[A-1:0]];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (n_cnt >= npts) begin
                            r_cnt   <= '0;
                            r_state <= S_MAC;
                        end else begin
                            r_cnt <= n_cnt;
                        end
                    end
                end
                S_MAC: begin
                    if (!issue) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (post_start) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (post_take) begin
                        r_state <= post_res.last ? S_LOAD : S_MAC;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // bin/sample counters and twiddle angle, angle steps by k*stride mod 64
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_k    <= '0;
            r_step <= '0;
            r_j    <= '0;
            r_ang  <= '0;
        end else if (issue) begin
            r_j     <= r_j + C'(1);
            r_ang   <= r_ang + r_step;
            r_ang_d <= r_ang;
        end else if (post_take) begin
            r_k    <= r_k + A'(1);
            r_step <= r_step + stride[A-1:0];
            r_j    <= '0;
            r_ang  <= '0;
        end
    end

    // mac pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_pre <= dds_pkg::PROD_W'(r_rd) *
                     dds_pkg::PROD_W'(dds_pkg::rom_sine(r_ang_d + A'(dds_pkg::MAX_POINTS / 4)));
            r_pim <= dds_pkg::PROD_W'(r_rd) * dds_pkg::PROD_W'(dds_pkg::rom_sine(r_ang_d));
        end
        if (r_state == S_LOAD || post_take) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + dds_pkg::ACC_W'(r_pre);
            r_acc_im <= r_acc_im - dds_pkg::ACC_W'(r_pim);
        end
    end

    dds_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (post_start),
        .i_re    (re_shr[dds_pkg::PART_W-1:0]),
        .i_im    (im_shr[dds_pkg::PART_W-1:0]),
        .i_bin   (r_k),
        .i_lg    (lg),
        .i_rate  (r_rate),
        .i_last  (k_last),
        .i_take  (post_take),
        .o_valid (post_valid),
        .o_res   (post_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (post_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (post_take) begin
            r_out <= post_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {3'b000, r_out.bin_frequency, r_out.phase, r_out.magnitude,
                            r_out.imag_part, r_out.real_part, r_out.bin_index};

endmodule

/* hdl/dds_checker.sv */
// ----------------------------------------------------------------------------
// dds_checker
// port-level checks of direct_dft_spectrum, bound to the top level
// ----------------------------------------------------------------------------
`include "direct_dft_spectrum_assert.svh"

module dds_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [dds_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input logic                                m_axis_tlast
);

    logic mag_zero;
    logic parts_zero;

    assign mag_zero   = (m_axis_tdata[dds_pkg::PHASE_LO-1:dds_pkg::MAG_LO] == '0);
    assign parts_zero = (m_axis_tdata[dds_pkg::MAG_LO-1:dds_pkg::REAL_LO] == '0) &&
                        (m_axis_tdata[dds_pkg::FREQ_LO-1:dds_pkg::PHASE_LO] == '0);

    // stalled output item holds
    `DDS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed under stall")

    // a non-final bin pending means the transform is running, so no sample loads
    `DDS_ASSERT_IMPLY(a_no_load_mid, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "sample accepted mid transform")

    // bin zero is never the final bin
    `DDS_ASSERT_IMPLY(a_bin0_not_last, m_axis_tvalid && m_axis_tdata[dds_pkg::REAL_LO-1:0] == '0, !m_axis_tlast, "bin zero flagged last")

    // zero magnitude only for an all-zero bin with zero phase
    `DDS_ASSERT_IMPLY(a_zero_bin, m_axis_tvalid && mag_zero, parts_zero, "zero magnitude with nonzero parts")

endmodule

bind direct_dft_spectrum dds_checker u_dds_checker (.*);

/* dv/direct_dft_spectrum_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_dft_spectrum checker
// watches the sample, config and spectrum channels, recomputes each frame's
// bins from the accepted samples and compares every spectrum item field by field
// ----------------------------------------------------------------------------
module direct_dft_spectrum_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_valid,
    input  logic                                i_s_ready,
    input  logic [dds_pkg::SAMPLE_WIDTH-1:0]    i_s_data,
    input  logic                                i_m_valid,
    input  logic                                i_m_ready,
    input  logic [dds_pkg::OUT_TDATA_W-1:0]     i_m_data,
    input  logic                                i_m_last,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [dds_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dds_pkg::RATE_W-1:0]          i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending
);

    logic [dds_pkg::LG_W-1:0]   lg_reg;
    logic [dds_pkg::RATE_W-1:0] rate_reg;
    logic signed [15:0]         frame_buf [64];
    int                         fill;
    dds_pkg::t_result           bins_due [$];

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sine_q15(int a);
        return longint'(dds_pkg::rom_sine(a[5:0]));
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint cordic_phase(longint re, longint im);
        longint x, y, z, xs, ys;
        x = re; y = im; z = 0;
        if (re == 0 && im == 0) return 0;
        if (re < 0) begin
            z = (im >= 0) ? 32768 : -32768;
            x = -re; y = -im;
        end
        for (int i = 0; i < 15; i++) begin
            xs = fshift(x, i); ys = fshift(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += longint'(dds_pkg::atan_step(i[3:0]));
            end else begin
                x -= ys; y += xs; z -= longint'(dds_pkg::atan_step(i[3:0]));
            end
        end
        if (z > 32767) z = 32767;
        if (z < -32768) z = -32768;
        return z;
    endfunction

    function automatic int points_log2();
        int lg;
        lg = int'(lg_reg);
        if (lg < 1) lg = 1;
        if (lg > 6) lg = 6;
        return lg;
    endfunction

    task automatic compute_spectrum(int lg);
        int               n, stride, a;
        longint           re_acc, im_acc, re, im;
        dds_pkg::t_result r;
        n = 1 << lg;
        stride = 64 / n;
        for (int k = 0; k < n; k++) begin
            re_acc = 0; im_acc = 0;
            for (int j = 0; j < n; j++) begin
                a = (k * j * stride) % 64;
                re_acc += longint'(frame_buf[j]) * sine_q15((a + 16) % 64);
                im_acc -= longint'(frame_buf[j]) * sine_q15(a);
            end
            re = fshift(re_acc, 15);
            im = fshift(im_acc, 15);
            r.bin_index     = k[dds_pkg::BIN_W-1:0];
            r.real_part     = re[dds_pkg::PART_W-1:0];
            r.imag_part     = im[dds_pkg::PART_W-1:0];
            r.magnitude     = dds_pkg::MAG_W'(int_sqrt(re * re + im * im));
            r.phase         = dds_pkg::PHASE_W'(cordic_phase(re, im));
            r.bin_frequency = dds_pkg::RATE_W'((longint'(k) * longint'(rate_reg)) >> lg);
            r.last          = (k == n - 1);
            bins_due = {bins_due, r};
        end
    endtask

    task automatic compare(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d actual %0d", name, want, got);
            o_errors++;
        end
    endtask

    assign o_pending = bins_due.size();

    always @(posedge i_clk) begin
        dds_pkg::t_result w;
        int               lg;
        if (!i_rst_n) begin
            lg_reg   <= dds_pkg::LG_RESET;
            rate_reg <= dds_pkg::RATE_RESET;
            fill = 0;
            bins_due.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == dds_pkg::CFG_LOG2) lg_reg <= i_cfg_data[dds_pkg::LG_W-1:0];
                else if (i_cfg_index == dds_pkg::CFG_RATE) rate_reg <= i_cfg_data;
            end
            if (i_s_valid && i_s_ready) begin
                lg = points_log2();
                if (fill < 64) frame_buf[fill] = i_s_data;
                fill = (fill + 1) % 128;
                if (fill >= (1 << lg)) begin
                    fill = 0;
                    compute_spectrum(lg);
                end
            end
            if (i_m_valid && i_m_ready) begin
                if (bins_due.size() == 0) begin
                    $error("spectrum item with nothing expected");
                    o_errors++;
                end else begin
                    w = bins_due.pop_front();
                    compare("bin_index", w.bin_index,
                            i_m_data[dds_pkg::REAL_LO-1:dds_pkg::BIN_LO]);
                    compare("real_part", w.real_part,
                            $signed(i_m_data[dds_pkg::IMAG_LO-1:dds_pkg::REAL_LO]));
                    compare("imag_part", w.imag_part,
                            $signed(i_m_data[dds_pkg::MAG_LO-1:dds_pkg::IMAG_LO]));
                    compare("magnitude", w.magnitude,
                            i_m_data[dds_pkg::PHASE_LO-1:dds_pkg::MAG_LO]);
                    compare("phase", w.phase,
                            $signed(i_m_data[dds_pkg::FREQ_LO-1:dds_pkg::PHASE_LO]));
                    compare("bin_frequency", w.bin_frequency,
                            i_m_data[dds_pkg::FREQ_HI:dds_pkg::FREQ_LO]);
                    compare("last", w.last, i_m_last);
                end
            end
        end
    end

endmodule

/* dv/direct_dft_spectrum_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_dft_spectrum testbench
// feeds sample frames at several point counts and rates with random gaps and
// output stalls; the checker predicts every bin and counts mismatches
// ----------------------------------------------------------------------------
module direct_dft_spectrum_tb;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [dds_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [dds_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                             m_axis_tlast;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [dds_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [dds_pkg::RATE_W-1:0]       i_cfg_data;
    int                               errors;
    int                               pending;
    int                               cycles;
    bit                               stall_on;

    localparam int CYCLE_LIMIT = 2_000_000;

    direct_dft_spectrum dut (.*);

    direct_dft_spectrum_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready), .i_s_data(s_axis_tdata),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready), .i_m_data(m_axis_tdata),
        .i_m_last(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAIL direct_dft_spectrum");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // output stalls, with stall-free stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b1;
        else if (!stall_on) m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 19) == 0) m_axis_tready <= 1'b0;
        else if (!m_axis_tready && $urandom_range(0, 2) != 0) m_axis_tready <= 1'b0;
        else m_axis_tready <= 1'b1;
    end

    // valid stays up between back-to-back items; drain() drops it
    task automatic send_sample(logic [15:0] v);
        int g;
        g = gap_len();
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(dds_pkg::t_cfg_idx idx, logic [dds_pkg::RATE_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        int lg;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = dds_pkg::CFG_LOG2;
        i_cfg_data    = '0;
        stall_on      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: two-point frames with extremes, zero frame, four-point impulse
        write_reg(dds_pkg::CFG_LOG2, 27'd1);
        write_reg(dds_pkg::CFG_RATE, 27'd1);
        send_sample(16'h7FFF); send_sample(16'h8000);
        send_sample(16'h8000); send_sample(16'h8000);
        send_sample(16'h0000); send_sample(16'h0000);
        drain();
        // log2 of zero acts as one, above six acts as six
        write_reg(dds_pkg::CFG_LOG2, 27'd0);
        write_reg(dds_pkg::CFG_RATE, 27'd100000000);
        send_sample(16'h7FFF); send_sample(16'h7FFF);
        drain();
        write_reg(dds_pkg::CFG_LOG2, 27'd2);
        send_sample(16'h7FFF); send_sample(16'h0000);
        send_sample(16'h0000); send_sample(16'h0000);
        send_sample(16'h5555); send_sample(16'hAAAA);
        send_sample(16'h0001); send_sample(16'hFFFF);
        drain();
        write_reg(dds_pkg::CFG_LOG2, 27'd7);
        write_reg(dds_pkg::CFG_RATE, 27'h7FFFFFF);
        for (int i = 0; i < 64; i++) send_sample(rand_sample());
        drain();

        // random: point count changes mid-frame, then frames at random sizes
        stall_on = 1'b1;
        write_reg(dds_pkg::CFG_LOG2, 27'd3);
        for (int i = 0; i < 5; i++) send_sample(rand_sample());
        drain();
        write_reg(dds_pkg::CFG_LOG2, 27'd2);
        send_sample(rand_sample());
        drain();
        for (int f = 0; f < 6; f++) begin
            lg = $urandom_range(1, 5);
            write_reg(dds_pkg::CFG_LOG2, dds_pkg::RATE_W'(lg));
            write_reg(dds_pkg::CFG_RATE, dds_pkg::RATE_W'($urandom_range(1, 100000000)));
            for (int i = 0; i < (1 << lg); i++) send_sample(rand_sample());
            drain();
        end

        if (errors == 0) begin
            $display("PASS direct_dft_spectrum");
        end else begin
            $display("FAIL direct_dft_spectrum");
        end
        $finish;
    end

endmodule
